// ===== hdl/uffv_pkg.sv =====
// Shared types and constants for the UART frame finder and validator.
// Holds the transaction structs, status codes and register indexes.
// No dependencies; compiled first.
`default_nettype none

package uffv_pkg;

  // Search span default: number of start offsets tried for the header.
  localparam int SEARCH_SPAN_DEF = 4;

  // Field widths.
  localparam int BYTE_W   = 8;
  localparam int POS_W    = 9;
  localparam int OFFSET_W = 2;
  localparam int INDEX_W  = 2;

  // Header is three bytes long; checksum is seeded with length minus two.
  localparam logic [POS_W-1:0]  HDR_LEN  = 9'd3;
  localparam logic [POS_W-1:0]  POS_MAX  = 9'd511;
  localparam logic [BYTE_W-1:0] SUM_BIAS = 8'd2;

  // Configuration register indexes.
  localparam logic [INDEX_W-1:0] REG_CHANNEL     = 2'd0;
  localparam logic [INDEX_W-1:0] REG_SYNC_FIRST  = 2'd1;
  localparam logic [INDEX_W-1:0] REG_SYNC_SECOND = 2'd2;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_HEADER = 2'd1,
    ST_TRUNCATED = 2'd2,
    ST_BAD_SUM   = 2'd3
  } status_t;

  // One received byte.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_buffer;
  } in_item_t;

  // One frame result.
  typedef struct packed {
    status_t             frame_status;
    logic [BYTE_W-1:0]   command_byte;
    logic [BYTE_W-1:0]   frame_length;
    logic [BYTE_W-1:0]   received_sum;
    logic [OFFSET_W-1:0] header_position;
  } out_item_t;

  // Header match values from the configuration registers.
  typedef struct packed {
    logic [BYTE_W-1:0] channel_byte;
    logic [BYTE_W-1:0] sync_first;
    logic [BYTE_W-1:0] sync_second;
  } hdr_cfg_t;

endpackage

`default_nettype wire

// ===== hdl/uart_frame_find_validate.sv =====
// Top level of the UART frame finder and validator.
// Holds the header registers and joins uffv_core to uffv_out_buf.
// Depends on uffv_pkg, uffv_core and uffv_out_buf.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+------------------------
//   in      | input     | in_valid / in_ready   | in_item_t, one byte
//   out     | output    | out_valid / out_ready | out_item_t, one result
//   cfg     | input     | cfg_we, no wait       | cfg_index, cfg_data
//
// Each byte passes through a compare against the header and an 8-bit add.
// A result is registered in the result buffer when the last byte of its buffer is accepted.
// The two-entry result buffer sets the stall: input is held only while
// two results wait at the output.
// Synchronous reset clears all buffer state and the header registers.
`default_nettype none

module uart_frame_find_validate
  import uffv_pkg::*;
#(
  parameter int SEARCH_SPAN = SEARCH_SPAN_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_item_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_item_t               out_data,
  input  wire logic               cfg_we,
  input  wire logic [INDEX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]  cfg_data
);

  hdr_cfg_t  hdr_cfg;
  logic      in_fire;
  logic      res_valid;
  out_item_t res_item;
  logic      space;

  // Header match registers; an unused index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHANNEL:     hdr_cfg.channel_byte <= cfg_data;
        REG_SYNC_FIRST:  hdr_cfg.sync_first   <= cfg_data;
        REG_SYNC_SECOND: hdr_cfg.sync_second  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = space;
  assign in_fire  = in_valid && in_ready;

  uffv_core #(
    .SEARCH_SPAN (SEARCH_SPAN)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_item   (in_data),
    .hdr_cfg   (hdr_cfg),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  uffv_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_item (res_item),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_data)
  );

endmodule

`default_nettype wire

// ===== hdl/uffv_core.sv =====
// Frame search and checksum state for one buffer at a time.
// Updates the per-buffer state on each accepted byte and forms the result.
// Depends on uffv_pkg.
`default_nettype none

module uffv_core
  import uffv_pkg::*;
#(
  parameter int SEARCH_SPAN = SEARCH_SPAN_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_fire,
  input  wire in_item_t  in_item,
  input  wire hdr_cfg_t  hdr_cfg,
  output logic           res_valid,
  output out_item_t      res_item
);

  // Per-buffer state.
  logic [POS_W-1:0]    byte_position, byte_position_next;
  logic [23:0]         recent_bytes, recent_bytes_next;
  logic                header_seen, header_seen_next;
  logic [OFFSET_W-1:0] start_offset, start_offset_next;
  logic [BYTE_W-1:0]   length_held, length_held_next;
  logic [BYTE_W-1:0]   command_held, command_held_next;
  logic [BYTE_W-1:0]   running_sum, running_sum_next;
  logic [BYTE_W-1:0]   payload_seen, payload_seen_next;
  logic [BYTE_W-1:0]   checksum_held, checksum_held_next;
  logic                outcome_known, outcome_known_next;
  status_t             outcome_code, outcome_code_next;

  logic [BYTE_W-1:0] b;
  logic              last;
  logic [POS_W-1:0]  pos_off;
  logic              in_span;
  logic              hdr_match;

  assign b    = in_item.data_byte;
  assign last = in_item.end_of_buffer;

  // Header window: offsets 0 to SEARCH_SPAN-1, with the last three bytes matching.
  assign pos_off   = byte_position - HDR_LEN;
  assign in_span   = (byte_position >= HDR_LEN) && (pos_off < POS_W'(SEARCH_SPAN));
  assign hdr_match = in_span &&
                     (recent_bytes[23:16] == hdr_cfg.channel_byte) &&
                     (recent_bytes[15:8]  == hdr_cfg.sync_first) &&
                     (recent_bytes[7:0]   == hdr_cfg.sync_second);

  // Next state and result for the byte at the input.
  always_comb begin
    byte_position_next = byte_position;
    recent_bytes_next  = {recent_bytes[15:0], b};
    header_seen_next   = header_seen;
    start_offset_next  = start_offset;
    length_held_next   = length_held;
    command_held_next  = command_held;
    running_sum_next   = running_sum;
    payload_seen_next  = payload_seen;
    checksum_held_next = checksum_held;
    outcome_known_next = outcome_known;
    outcome_code_next  = outcome_code;

    if (!outcome_known) begin
      if (header_seen) begin
        if (payload_seen < length_held) begin
          if (payload_seen == '0) begin
            command_held_next = b;
          end
          running_sum_next  = running_sum + b;
          payload_seen_next = payload_seen + 8'd1;
        end else begin
          checksum_held_next = b;
          outcome_known_next = 1'b1;
          outcome_code_next  = (running_sum == b) ? ST_OK : ST_BAD_SUM;
        end
      end else if (hdr_match) begin
        header_seen_next  = 1'b1;
        start_offset_next = pos_off[OFFSET_W-1:0];
        length_held_next  = b;
        running_sum_next  = b - SUM_BIAS;
        command_held_next = '0;
        payload_seen_next = '0;
      end
    end

    if (byte_position < POS_MAX) begin
      byte_position_next = byte_position + 9'd1;
    end

    // Result from the updated state.
    if (outcome_known_next) begin
      res_item.frame_status    = outcome_code_next;
      res_item.command_byte    = command_held_next;
      res_item.frame_length    = length_held_next;
      res_item.received_sum    = checksum_held_next;
      res_item.header_position = start_offset_next;
    end else if (header_seen_next) begin
      res_item.frame_status    = ST_TRUNCATED;
      res_item.command_byte    = '0;
      res_item.frame_length    = length_held_next;
      res_item.received_sum    = '0;
      res_item.header_position = start_offset_next;
    end else begin
      res_item.frame_status    = ST_NO_HEADER;
      res_item.command_byte    = '0;
      res_item.frame_length    = '0;
      res_item.received_sum    = '0;
      res_item.header_position = '0;
    end

    // The last byte closes the buffer and clears its state.
    if (last) begin
      byte_position_next = '0;
      recent_bytes_next  = '0;
      header_seen_next   = 1'b0;
      start_offset_next  = '0;
      length_held_next   = '0;
      command_held_next  = '0;
      running_sum_next   = '0;
      payload_seen_next  = '0;
      checksum_held_next = '0;
      outcome_known_next = 1'b0;
      outcome_code_next  = ST_OK;
    end
  end

  assign res_valid = in_fire && last;

  // State registers advance once per accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      recent_bytes  <= '0;
      header_seen   <= 1'b0;
      start_offset  <= '0;
      length_held   <= '0;
      command_held  <= '0;
      running_sum   <= '0;
      payload_seen  <= '0;
      checksum_held <= '0;
      outcome_known <= 1'b0;
      outcome_code  <= ST_OK;
    end else if (in_fire) begin
      byte_position <= byte_position_next;
      recent_bytes  <= recent_bytes_next;
      header_seen   <= header_seen_next;
      start_offset  <= start_offset_next;
      length_held   <= length_held_next;
      command_held  <= command_held_next;
      running_sum   <= running_sum_next;
      payload_seen  <= payload_seen_next;
      checksum_held <= checksum_held_next;
      outcome_known <= outcome_known_next;
      outcome_code  <= outcome_code_next;
    end
  end

  // A decision can only follow a found header.
  a_known_needs_header: assert property (@(posedge clk) disable iff (rst)
    outcome_known |-> header_seen)
    else $error("outcome decided without a header");

  // The payload count never passes the frame length.
  a_payload_bounded: assert property (@(posedge clk) disable iff (rst)
    header_seen |-> (payload_seen <= length_held))
    else $error("payload count beyond frame length");

  // The last byte of a buffer restarts the position count.
  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (in_fire && last) |=> (byte_position == '0) && !header_seen)
    else $error("buffer state not cleared after last byte");

endmodule

`default_nettype wire

// ===== hdl/uffv_out_buf.sv =====
// Two-entry result buffer: an output register plus a skid register.
// Lets the input side keep going while a result waits to be taken.
// Depends on uffv_pkg.
`default_nettype none

module uffv_out_buf
  import uffv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire out_item_t push_item,
  output logic           space,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  logic      skid_valid;
  out_item_t skid_item;

  assign space = !skid_valid;

  // Main register drains first; the skid entry moves up behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (push) begin
        skid_valid <= 1'b1;
        skid_item  <= push_item;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      out_item   <= skid_item;
      skid_valid <= push;
      skid_item  <= push_item;
    end else begin
      out_valid <= push;
      out_item  <= push_item;
    end
  end

  // The skid entry is only used behind a full output register.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  // No result arrives while both entries are full.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && skid_valid))
    else $error("result pushed into full buffer");

  // A waiting skid entry moves up when the output is taken.
  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready) |=> out_valid)
    else $error("skid entry lost on drain");

endmodule

`default_nettype wire

// ===== tb/uffv_checker.sv =====
// Checker for the UART frame finder and validator: watches the byte, result and
// register channels, predicts each frame result and compares it field by field.
// Depends on uffv_pkg for the transaction structs, status codes and register indexes.
module uffv_checker
  import uffv_pkg::*;
#(
  parameter int SEARCH_SPAN = SEARCH_SPAN_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire in_item_t           in_data,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire out_item_t          out_data,
  input  wire logic               cfg_we,
  input  wire logic [INDEX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]  cfg_data,
  output int                      failures,
  output int                      results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Header values as last written through the register port.
  hdr_cfg_t hdr_match;

  // Per-buffer tracking state, cleared after every last byte.
  logic [POS_W-1:0]  seen_count;
  logic [23:0]       last_three;
  bit                locked;
  logic [7:0]        hdr_offset;
  logic [7:0]        len_q;
  logic [7:0]        cmd_q;
  logic [7:0]        sum_acc;
  logic [8:0]        payload_count;
  logic [7:0]        chk_q;
  bit                decided;
  status_t           verdict;

  out_item_t results_due[$];
  int        mismatch_count = 0;
  int        due_count = 0;

  assign failures        = mismatch_count;
  assign results_pending = due_count;

  task automatic clear_frame();
    seen_count    = '0;
    last_three    = '0;
    locked        = 1'b0;
    hdr_offset    = '0;
    len_q         = '0;
    cmd_q         = '0;
    sum_acc       = '0;
    payload_count = '0;
    chk_q         = '0;
    decided       = 1'b0;
    verdict       = ST_OK;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 100) begin
      $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // Advance the frame search by one byte and queue a result on the last byte.
  task automatic track_byte(input in_item_t t);
    logic [7:0] b;
    out_item_t  r;
    b = t.data_byte;
    if (!decided) begin
      if (locked) begin
        if (payload_count < {1'b0, len_q}) begin
          if (payload_count == 0) cmd_q = b;
          sum_acc = sum_acc + b;
          payload_count = payload_count + 1'b1;
        end else begin
          // The byte after the payload decides the frame.
          chk_q   = b;
          decided = 1'b1;
          verdict = (sum_acc == b) ? ST_OK : ST_BAD_SUM;
        end
      end else if (seen_count >= HDR_LEN && int'(seen_count - HDR_LEN) < SEARCH_SPAN &&
                   last_three == hdr_match) begin
        // The three previous bytes hold the header, oldest in the top byte.
        locked        = 1'b1;
        hdr_offset    = 8'(seen_count - HDR_LEN);
        len_q         = b;
        sum_acc       = b - SUM_BIAS;
        cmd_q         = '0;
        payload_count = '0;
      end
    end

    last_three = {last_three[15:0], b};
    if (seen_count < POS_MAX) seen_count = seen_count + 1'b1;

    if (t.end_of_buffer) begin
      r = '0;
      if (decided) begin
        r.frame_status    = verdict;
        r.command_byte    = cmd_q;
        r.frame_length    = len_q;
        r.received_sum    = chk_q;
        r.header_position = hdr_offset[1:0];
      end else if (locked) begin
        r.frame_status    = ST_TRUNCATED;
        r.frame_length    = len_q;
        r.header_position = hdr_offset[1:0];
      end else begin
        r.frame_status = ST_NO_HEADER;
      end
      results_due.push_back(r);
      clear_frame();
    end
  endtask

  // Sample all three channels at each rising edge.
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      hdr_match = '0;
      clear_frame();
      results_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CHANNEL:     hdr_match.channel_byte = cfg_data;
          REG_SYNC_FIRST:  hdr_match.sync_first   = cfg_data;
          REG_SYNC_SECOND: hdr_match.sync_second  = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && in_ready) track_byte(in_data);

      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing expected", int'(out_data.frame_status), 0);
        end else begin
          want = results_due.pop_front();
          if (out_data.frame_status != want.frame_status)
            report_mismatch("frame_status", out_data.frame_status, want.frame_status);
          if (out_data.command_byte != want.command_byte)
            report_mismatch("command_byte", out_data.command_byte, want.command_byte);
          if (out_data.frame_length != want.frame_length)
            report_mismatch("frame_length", out_data.frame_length, want.frame_length);
          if (out_data.received_sum != want.received_sum)
            report_mismatch("received_sum", out_data.received_sum, want.received_sum);
          if (out_data.header_position != want.header_position)
            report_mismatch("header_position", out_data.header_position,
                            want.header_position);
        end
      end
    end
    due_count <= results_due.size();
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the UART frame finder and validator: drives receive buffers,
// header registers and output back-pressure, and gives the verdict.
// Depends on uffv_pkg, uart_frame_find_validate and uffv_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uffv_pkg::*;

  localparam int ITEMS_TARGET = 1900;
  localparam int HOLD_CYCLES  = 80;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;

  // Index with no register behind it; writes to it must be ignored.
  localparam logic [INDEX_W-1:0] REG_SPARE = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               cfg_we = 1'b0;
  logic [INDEX_W-1:0] cfg_index = REG_CHANNEL;
  logic [BYTE_W-1:0]  cfg_data = '0;

  int mismatches;
  int pending;

  // Stimulus bookkeeping.
  logic [7:0] frame_bytes[$];
  int         counted_items = 0;
  logic [7:0] cur_chan = '0;
  logic [7:0] cur_sync1 = '0;
  logic [7:0] cur_sync2 = '0;
  bit         sender_idles = 1'b0;
  bit         receiver_idles = 1'b0;
  bit         hold_request = 1'b0;
  int         quiet_cycles = 0;

  always #5 clk = ~clk;

  uart_frame_find_validate dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_data
  );

  uffv_checker frame_check (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_data, .failures(mismatches), .results_pending(pending)
  );

  // Watchdog: give up after a long stretch with no transaction on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: a long hold when asked, random stall bursts while receiver_idles is set, otherwise ready.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one byte and wait until it is accepted.
  task automatic send_byte(input logic [7:0] b, input bit last);
    if (sender_idles && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.data_byte <= b;
    in_data.end_of_buffer <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    counted_items += frame_bytes.size();
  endtask

  // Stop offering bytes until every expected result has come out.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all header registers, then the unused index with junk.
  task automatic write_header_regs(input logic [7:0] chan, input logic [7:0] s1,
                                   input logic [7:0] s2);
    logic [INDEX_W-1:0] idx[4];
    logic [7:0]         val[4];
    idx = '{REG_CHANNEL, REG_SYNC_FIRST, REG_SYNC_SECOND, REG_SPARE};
    val = '{chan, s1, s2, 8'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    cur_chan  = chan;
    cur_sync1 = s1;
    cur_sync2 = s2;
  endtask

  // Build a buffer: lead bytes, header, length, payload, checksum, then either a
  // cut at byte count cut (when shorter than the full frame) or ignored tail bytes.
  task automatic make_frame(input int lead, input int len, input bit sum_ok,
                            input int cut, input int tail);
    logic [7:0] sum;
    logic [7:0] b;
    frame_bytes.delete();
    repeat (lead) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(cur_chan);
    frame_bytes.push_back(cur_sync1);
    frame_bytes.push_back(cur_sync2);
    frame_bytes.push_back(8'(len));
    sum = 8'(len) - SUM_BIAS;
    repeat (len) begin
      b = 8'($urandom);
      sum += b;
      frame_bytes.push_back(b);
    end
    if (!sum_ok) sum += 8'($urandom_range(1, 255));
    frame_bytes.push_back(sum);
    if (cut > 0 && cut < frame_bytes.size()) begin
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end else begin
      repeat (tail) frame_bytes.push_back(8'($urandom));
    end
  endtask

  // Noise drawn mostly from the header values, so partial headers show up.
  task automatic make_noise(input int n);
    frame_bytes.delete();
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       frame_bytes.push_back(cur_chan);
        1:       frame_bytes.push_back(cur_sync1);
        2:       frame_bytes.push_back(cur_sync2);
        default: frame_bytes.push_back(8'($urandom));
      endcase
    end
  endtask

  // Mostly well-formed frames, some with bad checksums, with truncated, noisy and late-header buffers mixed in.
  task automatic random_frame();
    int kind;
    int lead;
    int len;
    kind = $urandom_range(0, 99);
    lead = $urandom_range(0, 3);
    len  = ($urandom_range(0, 24) == 0) ? $urandom_range(9, 255) : $urandom_range(0, 8);
    if (kind < 70)
      make_frame(lead, len, $urandom_range(0, 7) != 0, 0,
                 ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
    else if (kind < 82)
      make_frame(lead, len, 1'b1, $urandom_range(1, lead + len + 4), 0);
    else if (kind < 94)
      make_noise($urandom_range(1, 10));
    else
      make_frame($urandom_range(4, 6), len, 1'b1, 0, 0);
    send_frame();
  endtask

  initial begin
    int   phase;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Header registers at their reset value of zero: header at offset 0, bad checksum.
    frame_bytes = {8'h00, 8'h00, 8'h00, 8'h00, 8'h12};
    send_frame();
    wait_results_done();

    receiver_idles = 1'b1;
    write_header_regs(8'hFF, 8'h00, 8'hA5);
    // Header at the last offset searched, one payload byte, good checksum.
    frame_bytes = {8'h11, 8'h22, 8'h33, 8'hFF, 8'h00, 8'hA5, 8'h01, 8'h80, 8'h7F};
    send_frame();
    // Header one offset too late: no header.
    frame_bytes = {8'h11, 8'h11, 8'h11, 8'h11, 8'hFF, 8'h00, 8'hA5, 8'h00};
    send_frame();
    // Buffer ends inside the payload: truncated.
    frame_bytes = {8'hFF, 8'h00, 8'hA5, 8'h02, 8'hFF};
    send_frame();

    // Random phases, each with its own header values and idling pattern.
    phase = 0;
    while (counted_items < ITEMS_TARGET) begin
      wait_results_done();
      case (phase % 5)
        0: begin c0 = 8'hFF; c1 = 8'hFF; c2 = 8'hFF; end
        1: begin c0 = 8'h00; c1 = 8'h00; c2 = 8'h00; end
        2: begin
          c0 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          c1 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          c2 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        default: begin
          c0 = 8'($urandom);
          c1 = ($urandom_range(0, 2) == 0) ? c0 : 8'($urandom);
          c2 = ($urandom_range(0, 2) == 0) ? c1 : 8'($urandom);
        end
      endcase
      write_header_regs(c0, c1, c2);

      sender_idles   = (counted_items < ITEMS_TARGET - 300) && ($urandom_range(0, 3) != 0);
      receiver_idles = (counted_items < ITEMS_TARGET - 300) && ($urandom_range(0, 3) != 0);

      // Hold the result side while one-byte buffers keep coming, to fill the block.
      if (phase == 3) begin
        hold_request = 1'b1;
        repeat (40) begin
          make_noise(1);
          send_frame();
        end
      end
      // A buffer longer than the position counter's range, with ignored bytes at the end.
      if (phase == 6) begin
        make_frame(2, 255, 1'b1, 0, 300);
        send_frame();
      end

      repeat ($urandom_range(8, 20)) random_frame();
      phase++;
    end
    wait_results_done();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
